// ----- hw/rtl/lda_gibbs_topic_sampler_core_defines.svh -----
// Assertion helpers for the topic sampler
`ifndef LDA_GIBBS_TOPIC_SAMPLER_CORE_DEFINES_SVH
`define LDA_GIBBS_TOPIC_SAMPLER_CORE_DEFINES_SVH

// Check a consequence in the same cycle
`define LGTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the next cycle
`define LGTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/lgts_pkg.sv -----
`default_nettype none
package lgts_pkg;

  localparam int MAX_DOCS   = 4096;
  localparam int MAX_TOPICS = 64;
  localparam int MAX_VOCAB  = 16384;

  localparam int DOC_W   = 12;
  localparam int WORD_W  = 14;
  localparam int TOPIC_W = 6;
  localparam int RND_W   = 32;
  localparam int NT_W    = 7;
  localparam int VOC_W   = 15;
  localparam int PRI_W   = 24;

  localparam int DT_W    = 16;
  localparam int TW_W    = 24;
  localparam int TT_W    = 32;
  localparam int DT_AW   = DOC_W + TOPIC_W;
  localparam int TW_AW   = TOPIC_W + WORD_W;
  localparam int CLR_W   = TW_AW;

  localparam int A_W     = 33;
  localparam int B_W     = 41;
  localparam int VB_W    = PRI_W + VOC_W;
  localparam int DEN_W   = 49;
  localparam int NUM_W   = 74;
  localparam int WGT_W   = 42;
  localparam int CUM_W   = 48;
  localparam int CNT_W   = 7;

  typedef struct packed {
    logic               kind;
    logic [DOC_W-1:0]   doc_id;
    logic [WORD_W-1:0]  word_id;
    logic [TOPIC_W-1:0] topic;
    logic [RND_W-1:0]   random;
  } in_word_t;

  typedef struct packed {
    logic [TOPIC_W-1:0] new_topic;
    logic               status;
  } out_word_t;

  typedef enum logic [1:0] {
    CFG_ALPHA = 2'd0,
    CFG_BETA  = 2'd1,
    CFG_NTOP  = 2'd2,
    CFG_VOCAB = 2'd3
  } cfg_idx_t;

  typedef enum logic [4:0] {
    OP_CLR, OP_IDLE, OP_RM_RD, OP_RM_WR, OP_W_RD, OP_W_AB, OP_W_M0, OP_W_M1,
    OP_W_M2, OP_DIV_GO, OP_DIV_WAIT, OP_W_ACC, OP_P0, OP_P1, OP_P2, OP_S_RD,
    OP_S_CMP, OP_AD_RD, OP_AD_WR, OP_OUT
  } lgts_op_t;

  typedef struct packed {
    lgts_op_t op;
  } lgts_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic item_err;
    logic item_kind;
    logic k_last;
    logic div_busy;
    logic hit;
    logic out_free;
  } lgts_sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/lgts_div.sv -----
`default_nettype none
module lgts_div import lgts_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  busy,
  output logic [WGT_W-1:0]      quo
);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_r, rem_nxt, rem_sh;
  logic [WGT_W-1:0] q_r, q_nxt;
  logic             sat_r, sat_nxt;

  // one quotient bit per step, saturate once the quotient leaves its range
  always_comb begin
    rem_sh  = {rem_r[DEN_W-1:0], num_r[NUM_W-1]};
    sat_nxt = sat_r | q_r[WGT_W-1];
    q_nxt   = q_r[WGT_W-1] ? q_r : {q_r[WGT_W-2:0], 1'b0};
    rem_nxt = rem_sh;
    if (rem_sh >= {1'b0, den_r}) begin
      rem_nxt  = rem_sh - {1'b0, den_r};
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      sat_r <= 1'b0;
      if (den == '0) begin
        busy_r <= 1'b0;
        q_r    <= (num != '0) ? '1 : '0;
      end else begin
        busy_r <= 1'b1;
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
        q_r    <= '0;
        cnt_r  <= CNT_W'(NUM_W - 1);
      end
    end else if (busy_r) begin
      num_r <= num_r << 1;
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      sat_r <= sat_nxt;
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quo  = sat_r ? '1 : q_r;

endmodule
`default_nettype wire

// ----- hw/rtl/lgts_dp.sv -----
`default_nettype none
module lgts_dp import lgts_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire lgts_cmd_t  cmd,
  output lgts_sts_t       sts,
  input  wire logic       in_valid,
  input  wire in_word_t   in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_word_t       out_data,
  input  wire logic       cfg_valid,
  input  wire logic [1:0] cfg_index,
  input  wire logic [PRI_W-1:0] cfg_data
);

  // configuration
  logic [PRI_W-1:0] alpha_r, beta_r;
  logic [NT_W-1:0]  ntop_r, nt_use;
  logic [VOC_W-1:0] vocab_r, v_use;
  logic [VB_W-1:0]  vb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= PRI_W'(65536);
      beta_r  <= PRI_W'(6554);
      ntop_r  <= NT_W'(MAX_TOPICS);
      vocab_r <= VOC_W'(MAX_VOCAB);
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ALPHA: alpha_r <= cfg_data;
        CFG_BETA:  beta_r  <= cfg_data;
        CFG_NTOP:  ntop_r  <= cfg_data[NT_W-1:0];
        CFG_VOCAB: vocab_r <= cfg_data[VOC_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp counts in use
  always_comb begin
    nt_use = ntop_r;
    if (ntop_r == '0) nt_use = NT_W'(1);
    else if (ntop_r > NT_W'(MAX_TOPICS)) nt_use = NT_W'(MAX_TOPICS);
    v_use = vocab_r;
    if (vocab_r == '0) v_use = VOC_W'(1);
    else if (vocab_r > VOC_W'(MAX_VOCAB)) v_use = VOC_W'(MAX_VOCAB);
  end

  always_ff @(posedge clk) begin
    vb_r <= VB_W'(beta_r) * VB_W'(v_use);
  end

  // item registers
  logic               accept;
  logic               item_err;
  logic               kind_r, err_r;
  logic [DOC_W-1:0]   doc_r;
  logic [WORD_W-1:0]  word_r;
  logic [TOPIC_W-1:0] t_in_r, t_new_r, k_r, t_sel;
  logic [RND_W-1:0]   rnd_r;

  assign accept   = (cmd.op == OP_IDLE) && in_valid;
  assign item_err = ({1'b0, in_data.doc_id} >= (DOC_W+1)'(MAX_DOCS)) ||
                    ({1'b0, in_data.word_id} >= (WORD_W+1)'(v_use)) ||
                    ({1'b0, in_data.topic} >= nt_use);

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= in_data.kind;
      err_r   <= item_err;
      doc_r   <= in_data.doc_id;
      word_r  <= in_data.word_id;
      t_in_r  <= in_data.topic;
      t_new_r <= in_data.topic;
      rnd_r   <= in_data.random;
    end else if (cmd.op == OP_S_CMP && (sts.hit || sts.k_last)) begin
      t_new_r <= k_r;
    end
  end

  // topic counter for the weight and search passes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else begin
      case (cmd.op)
        OP_RM_WR, OP_P0: k_r <= '0;
        OP_W_ACC:        if (!sts.k_last) k_r <= k_r + 1'b1;
        OP_S_CMP:        if (!(sts.hit || sts.k_last)) k_r <= k_r + 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd.op)
      OP_RM_RD, OP_RM_WR: t_sel = t_in_r;
      OP_AD_RD, OP_AD_WR: t_sel = t_new_r;
      default:            t_sel = k_r;
    endcase
  end

  // clearing sweep counter
  logic [CLR_W-1:0] clr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.op == OP_CLR) clr_r <= clr_r + 1'b1;
  end

  // count stores
  logic [DT_W-1:0] dt_mem [1<<DT_AW];
  logic [TW_W-1:0] tw_mem [1<<TW_AW];
  logic [TT_W-1:0] tt_mem [MAX_TOPICS];
  logic [DT_W-1:0] dt_rd_r, dt_wd;
  logic [TW_W-1:0] tw_rd_r, tw_wd;
  logic [TT_W-1:0] tt_rd_r, tt_wd;
  logic [DT_AW-1:0] dt_a, dt_wa;
  logic [TW_AW-1:0] tw_a, tw_wa;
  logic [TOPIC_W-1:0] tt_wa;
  logic cnt_we;

  assign dt_a = {doc_r, t_sel};
  assign tw_a = {t_sel, word_r};

  // pick write port source: sweep, remove or add
  always_comb begin
    cnt_we = 1'b1;
    dt_wa  = dt_a;
    tw_wa  = tw_a;
    tt_wa  = t_sel;
    dt_wd  = '0;
    tw_wd  = '0;
    tt_wd  = '0;
    case (cmd.op)
      OP_CLR: begin
        dt_wa = clr_r[DT_AW-1:0];
        tw_wa = clr_r;
        tt_wa = clr_r[TOPIC_W-1:0];
      end
      OP_RM_WR: begin
        dt_wd = (dt_rd_r == '0) ? '0 : dt_rd_r - 1'b1;
        tw_wd = (tw_rd_r == '0) ? '0 : tw_rd_r - 1'b1;
        tt_wd = (tt_rd_r == '0) ? '0 : tt_rd_r - 1'b1;
      end
      OP_AD_WR: begin
        dt_wd = (dt_rd_r == '1) ? dt_rd_r : dt_rd_r + 1'b1;
        tw_wd = (tw_rd_r == '1) ? tw_rd_r : tw_rd_r + 1'b1;
        tt_wd = (tt_rd_r == '1) ? tt_rd_r : tt_rd_r + 1'b1;
      end
      default: cnt_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      dt_mem[dt_wa] <= dt_wd;
      tw_mem[tw_wa] <= tw_wd;
      tt_mem[tt_wa] <= tt_wd;
    end
    dt_rd_r <= dt_mem[dt_a];
    tw_rd_r <= tw_mem[tw_a];
    tt_rd_r <= tt_mem[t_sel];
  end

  // weight operands and shared multiplier
  logic [A_W-1:0]   a_r;
  logic [B_W-1:0]   b_r;
  logic [DEN_W-1:0] d_r;
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      mul_r;
  logic [NUM_W-1:0] prod_r;
  logic [CUM_W-1:0] acc_r, p_r;
  logic [CUM_W:0]   acc_sum;
  logic             div_busy;
  logic [WGT_W-1:0] div_q;

  always_comb begin
    mul_a = a_r[31:0];
    mul_b = b_r[31:0];
    case (cmd.op)
      OP_W_M1: mul_b = 32'(b_r[B_W-1:32]);
      OP_P0:   begin mul_a = rnd_r; mul_b = acc_r[31:0]; end
      OP_P1:   begin mul_a = rnd_r; mul_b = 32'(acc_r[CUM_W-1:32]); end
      default: ;
    endcase
  end

  assign acc_sum = {1'b0, acc_r} + (CUM_W+1)'(div_q);

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
    case (cmd.op)
      OP_W_AB: begin
        a_r <= A_W'({dt_rd_r, 16'b0}) + A_W'(alpha_r);
        b_r <= B_W'({tw_rd_r, 16'b0}) + B_W'(beta_r);
        d_r <= DEN_W'({tt_rd_r, 16'b0}) + DEN_W'(vb_r);
      end
      OP_W_M1: prod_r <= NUM_W'(mul_r);
      OP_W_M2: prod_r <= prod_r + (NUM_W'(mul_r) << 32) +
                         (a_r[32] ? (NUM_W'(b_r) << 32) : '0);
      OP_P1:   p_r <= CUM_W'(mul_r >> 32);
      OP_P2:   p_r <= p_r + CUM_W'(mul_r);
      default: ;
    endcase
  end

  // running sum of weights, saturate at the top
  always_ff @(posedge clk) begin
    if (cmd.op == OP_RM_WR) acc_r <= '0;
    else if (cmd.op == OP_W_ACC) acc_r <= acc_sum[CUM_W] ? '1 : acc_sum[CUM_W-1:0];
  end

  lgts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == OP_DIV_GO),
    .num   (prod_r),
    .den   (d_r),
    .busy  (div_busy),
    .quo   (div_q)
  );

  // cumulative weight store
  logic [CUM_W-1:0] cum_mem [MAX_TOPICS];
  logic [CUM_W-1:0] cum_rd_r;
  always_ff @(posedge clk) begin
    if (cmd.op == OP_W_ACC) cum_mem[k_r] <= acc_sum[CUM_W] ? '1 : acc_sum[CUM_W-1:0];
    cum_rd_r <= cum_mem[k_r];
  end

  // result register
  logic      out_valid_r;
  out_word_t out_data_r;
  logic      out_free;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_OUT && out_free) begin
      out_valid_r <= 1'b1;
      out_data_r  <= '{new_topic: t_new_r, status: err_r};
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.clr_done  = (clr_r == '1);
  assign sts.item_err  = item_err;
  assign sts.item_kind = in_data.kind;
  assign sts.k_last    = ({1'b0, k_r} == nt_use - 1'b1);
  assign sts.div_busy  = div_busy;
  assign sts.hit       = (cum_rd_r > p_r);
  assign sts.out_free  = out_free;

endmodule
`default_nettype wire

// ----- hw/rtl/lgts_ctrl.sv -----
`default_nettype none
module lgts_ctrl import lgts_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire lgts_sts_t sts,
  output lgts_cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_RM_RD, S_RM_WR, S_W_RD, S_W_AB, S_W_M0, S_W_M1, S_W_M2,
    S_DIV_GO, S_DIV_WAIT, S_W_ACC, S_P0, S_P1, S_P2, S_S_RD, S_S_CMP,
    S_AD_RD, S_AD_WR, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:      if (sts.clr_done) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          if (sts.item_err) state_nxt = S_OUT;
          else if (!sts.item_kind) state_nxt = S_AD_RD;
          else state_nxt = S_RM_RD;
        end
      end
      S_RM_RD:    state_nxt = S_RM_WR;
      S_RM_WR:    state_nxt = S_W_RD;
      S_W_RD:     state_nxt = S_W_AB;
      S_W_AB:     state_nxt = S_W_M0;
      S_W_M0:     state_nxt = S_W_M1;
      S_W_M1:     state_nxt = S_W_M2;
      S_W_M2:     state_nxt = S_DIV_GO;
      S_DIV_GO:   state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: if (!sts.div_busy) state_nxt = S_W_ACC;
      S_W_ACC:    state_nxt = sts.k_last ? S_P0 : S_W_RD;
      S_P0:       state_nxt = S_P1;
      S_P1:       state_nxt = S_P2;
      S_P2:       state_nxt = S_S_RD;
      S_S_RD:     state_nxt = S_S_CMP;
      S_S_CMP:    state_nxt = (sts.hit || sts.k_last) ? S_AD_RD : S_S_RD;
      S_AD_RD:    state_nxt = S_AD_WR;
      S_AD_WR:    state_nxt = S_OUT;
      S_OUT:      if (sts.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_CLR;
    endcase
  end

  // hold state and the input stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      in_stall_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != S_IDLE);
    end
  end

  assign in_stall = in_stall_r;

  // decode command
  always_comb begin
    unique case (state_r)
      S_CLR:      cmd.op = OP_CLR;
      S_IDLE:     cmd.op = OP_IDLE;
      S_RM_RD:    cmd.op = OP_RM_RD;
      S_RM_WR:    cmd.op = OP_RM_WR;
      S_W_RD:     cmd.op = OP_W_RD;
      S_W_AB:     cmd.op = OP_W_AB;
      S_W_M0:     cmd.op = OP_W_M0;
      S_W_M1:     cmd.op = OP_W_M1;
      S_W_M2:     cmd.op = OP_W_M2;
      S_DIV_GO:   cmd.op = OP_DIV_GO;
      S_DIV_WAIT: cmd.op = OP_DIV_WAIT;
      S_W_ACC:    cmd.op = OP_W_ACC;
      S_P0:       cmd.op = OP_P0;
      S_P1:       cmd.op = OP_P1;
      S_P2:       cmd.op = OP_P2;
      S_S_RD:     cmd.op = OP_S_RD;
      S_S_CMP:    cmd.op = OP_S_CMP;
      S_AD_RD:    cmd.op = OP_AD_RD;
      S_AD_WR:    cmd.op = OP_AD_WR;
      S_OUT:      cmd.op = OP_OUT;
      default:    cmd.op = OP_CLR;
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/lda_gibbs_topic_sampler_core.sv -----
// Collapsed Gibbs topic sampler. One word in, one result word out. After reset
// the count stores are swept clear, one entry per cycle over 1,048,576 addresses,
// with the input stalled; configuration writes are taken throughout. A kind-0
// word (add) reads and increments its counts, then posts its result; a word with
// an id or topic out of range only posts its result. A kind-1 word (resample)
// decrements the counts of its old topic, computes a weight for each of the T
// topics in use, draws, scans the cumulative weights up to and including the
// topic the draw hits, then increments the counts of the new topic. Each topic
// costs three count store reads, a multiply split over the shared 32x32
// multiplier and a restoring divider that yields one quotient bit per cycle
// (74 steps). A word waits to post its result while the stalled output register
// is full; a finished result waits there while the next word is accepted.
`default_nettype none
`include "lda_gibbs_topic_sampler_core_defines.svh"
module lda_gibbs_topic_sampler_core import lgts_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_word_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_word_t             out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [PRI_W-1:0] cfg_data
);

  lgts_cmd_t cmd;
  lgts_sts_t sts;

  assign cfg_ready = 1'b1;

  lgts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lgts_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_valid  (in_valid && !in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  `LGTS_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "second word taken while busy")
  `LGTS_ASSERT_NOW(a_clr_stall, cmd.op == OP_CLR, in_stall, "word taken during clearing sweep")
  `LGTS_ASSERT_NOW(a_div_wait, sts.div_busy, cmd.op == OP_DIV_WAIT, "divider busy outside wait")

endmodule
`default_nettype wire

// ----- verif/tb_lda_gibbs_topic_sampler_core.sv -----
`default_nettype none
module tb_lda_gibbs_topic_sampler_core;
  import lgts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint WEIGHT_MAX = (64'd1 << 42) - 1;
  localparam longint CUM_MAX    = (64'd1 << 48) - 1;
  localparam longint CYCLE_LIMIT = 40_000_000;

  // Mirror of the count stores; predicts the topic for every accepted word
  class topic_tally;
    bit [DT_W-1:0] doc_topic[MAX_DOCS*MAX_TOPICS];
    bit [TW_W-1:0] topic_word[MAX_TOPICS*MAX_VOCAB];
    bit [TT_W-1:0] topic_sum[MAX_TOPICS];
    bit [PRI_W-1:0] alpha, beta;
    bit [NT_W-1:0] ntop_raw;
    bit [VOC_W-1:0] vocab_raw;
    out_word_t expected_topics[$];
    int mismatches;

    function new();
      alpha = 24'd65536;
      beta = 24'd6554;
      ntop_raw = 7'd64;
      vocab_raw = 15'd16384;
      mismatches = 0;
    endfunction

    function int ntop();
      if (ntop_raw == 0) return 1;
      return (ntop_raw > MAX_TOPICS) ? MAX_TOPICS : int'(ntop_raw);
    endfunction

    function int vocab();
      if (vocab_raw == 0) return 1;
      return (vocab_raw > MAX_VOCAB) ? MAX_VOCAB : int'(vocab_raw);
    endfunction

    function void write_reg(cfg_idx_t idx, bit [PRI_W-1:0] val);
      case (idx)
        CFG_ALPHA: alpha = val;
        CFG_BETA:  beta = val;
        CFG_NTOP:  ntop_raw = val[NT_W-1:0];
        CFG_VOCAB: vocab_raw = val[VOC_W-1:0];
        default: ;
      endcase
    endfunction

    function void bump(int d, int w, int t);
      if (doc_topic[d*MAX_TOPICS+t] != '1) doc_topic[d*MAX_TOPICS+t]++;
      if (topic_word[t*MAX_VOCAB+w] != '1) topic_word[t*MAX_VOCAB+w]++;
      if (topic_sum[t] != '1) topic_sum[t]++;
    endfunction

    function void drop(int d, int w, int t);
      if (doc_topic[d*MAX_TOPICS+t] != 0) doc_topic[d*MAX_TOPICS+t]--;
      if (topic_word[t*MAX_VOCAB+w] != 0) topic_word[t*MAX_VOCAB+w]--;
      if (topic_sum[t] != 0) topic_sum[t]--;
    endfunction

    // Draw a topic from the cumulative Q.16 weights
    function int draw(int d, int w, bit [31:0] rnd);
      bit [63:0] cum[MAX_TOPICS];
      bit [63:0] acc, a, b, den, vb, wgt, p;
      bit [127:0] prod, quo;
      int nt;
      nt = ntop();
      vb = 64'(beta) * 64'(vocab());
      acc = 0;
      for (int k = 0; k < nt; k++) begin
        a = (64'(doc_topic[d*MAX_TOPICS+k]) << 16) + 64'(alpha);
        b = (64'(topic_word[k*MAX_VOCAB+w]) << 16) + 64'(beta);
        den = (64'(topic_sum[k]) << 16) + vb;
        prod = 128'(a) * 128'(b);
        if (den == 0) begin
          wgt = (prod != 0) ? WEIGHT_MAX : 0;
        end else begin
          quo = prod / 128'(den);
          wgt = (quo > 128'(WEIGHT_MAX)) ? WEIGHT_MAX : quo[63:0];
        end
        acc = acc + wgt;
        if (acc > CUM_MAX) acc = CUM_MAX;
        cum[k] = acc;
      end
      prod = 128'(rnd) * 128'(cum[nt-1]);
      p = prod[95:32];
      for (int k = 0; k < nt; k++)
        if (cum[k] > p) return k;
      return nt - 1;
    endfunction

    // Predict the result of one accepted word
    function void note_token(in_word_t tok);
      out_word_t res;
      int t;
      t = tok.topic;
      res.status = 1'b0;
      if (int'(tok.word_id) >= vocab() || t >= ntop()) begin
        res.status = 1'b1;
      end else if (tok.kind == 1'b0) begin
        bump(tok.doc_id, tok.word_id, t);
      end else begin
        drop(tok.doc_id, tok.word_id, t);
        t = draw(tok.doc_id, tok.word_id, tok.random);
        bump(tok.doc_id, tok.word_id, t);
      end
      res.new_topic = TOPIC_W'(t);
      expected_topics = {expected_topics, res};
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (expected_topics.size() == 0) begin
        $error("unexpected result word new_topic=%0d status=%0d", got.new_topic, got.status);
        mismatches++;
        return;
      end
      want = expected_topics.pop_front();
      if (got.new_topic !== want.new_topic) begin
        $error("new_topic: expected %0d, actual %0d", want.new_topic, got.new_topic);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        mismatches++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  in_word_t in_data;
  out_word_t out_data;
  logic [1:0] cfg_index;
  logic [PRI_W-1:0] cfg_data;

  topic_tally tally;
  bit quiet;
  int stall_left;
  longint cycles;

  lda_gibbs_topic_sampler_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Check each accepted result word and redraw the receiver stall
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      tally.check_result(out_data);
      stall_left = quiet ? 0 : $urandom_range(0, 13);
    end
  end

  // Hold stall for the drawn count, then release
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_word(in_word_t w);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    tally.note_token(w);
  endtask

  // Lower valid and wait until every result has come back
  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    while (tally.expected_topics.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [PRI_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    tally.write_reg(idx, val);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic set_all(logic [23:0] a, logic [23:0] b, logic [23:0] nt, logic [23:0] v);
    write_reg(CFG_ALPHA, a);
    write_reg(CFG_BETA, b);
    write_reg(CFG_NTOP, nt);
    write_reg(CFG_VOCAB, v);
  endtask

  function automatic in_word_t make_word(bit k, int d, int w, int t, bit [31:0] r);
    in_word_t x;
    x.kind = k;
    x.doc_id = DOC_W'(d);
    x.word_id = WORD_W'(w);
    x.topic = TOPIC_W'(t);
    x.random = r;
    return x;
  endfunction

  // Mostly well-formed add/resample traffic on a few docs and words, some noise
  task automatic random_phase(int count);
    in_word_t w;
    int nt, v, sel;
    nt = tally.ntop();
    v = tally.vocab();
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 9);
      w = make_word(sel >= 3, $urandom_range(0, 3),
                    $urandom_range(0, (v > 8 ? 8 : v) - 1),
                    $urandom_range(0, nt - 1), $urandom());
      if (sel == 0) w = in_word_t'($urandom() ^ ({$urandom(), $urandom()} << 7));
      if (sel == 1) w.doc_id = DOC_W'($urandom());
      send_word(w);
      if (i == count / 2) drain();
    end
    drain();
  endtask

  initial begin
    tally = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ALPHA;
    cfg_data = '0;
    quiet = 1'b0;
    stall_left = 0;
    cycles = 0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Extremes at the reset setting
    send_word(make_word(0, 0, 0, 0, 0));
    send_word(make_word(0, 4095, 16383, 63, 32'hFFFF_FFFF));
    send_word(make_word(1, 0, 0, 0, 0));
    send_word(make_word(1, 4095, 16383, 63, 32'hFFFF_FFFF));
    send_word(make_word(1, 5, 7, 9, 32'h8000_0000));
    send_word(make_word(1, 2730, 10922, 42, 32'h5555_5555));
    drain();

    // Zero priors: zero denominator and the draw past the end
    set_all(0, 0, 3, 5);
    send_word(make_word(1, 1, 1, 1, 32'h1234_5678));
    send_word(make_word(0, 1, 1, 2, 0));
    send_word(make_word(1, 1, 1, 2, 32'hFFFF_FFFF));
    send_word(make_word(1, 1, 2, 0, 0));
    send_word(make_word(1, 1, 5, 0, 0));
    send_word(make_word(0, 1, 0, 3, 0));
    send_word(make_word(1, 4095, 16383, 63, 0));
    random_phase(80);

    // Largest priors with one topic and one word
    set_all(24'hFF_FFFF, 24'hFF_FFFF, 1, 1);
    random_phase(60);

    // Zero counts taken as one; out-of-width bits masked off
    set_all(24'h00_0001, 24'h00_0001, 24'h00_FF80, 24'hFF_8000);
    random_phase(60);

    // Counts above the maximum clamped
    set_all(24'($urandom_range(0, 24'hFF_FFFF)), 24'($urandom_range(0, 24'hFF_FFFF)),
            127, 32767);
    random_phase(20);

    for (int ph = 0; ph < 8; ph++) begin
      set_all(24'($urandom_range(0, 24'h0F_FFFF)), 24'($urandom_range(0, 24'h0F_FFFF)),
              24'($urandom_range(1, 8)), 24'($urandom_range(1, 40)));
      random_phase(100);
    end

    quiet = 1'b0;
    if (tally.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/lgts_pkg.sv
hw/rtl/lgts_div.sv
hw/rtl/lgts_dp.sv
hw/rtl/lgts_ctrl.sv
hw/rtl/lda_gibbs_topic_sampler_core.sv
verif/tb_lda_gibbs_topic_sampler_core.sv
